// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the thermostat RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on the rising clock edge, idle while reset is asserted.
`define THM_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);
// Check a property on the rising clock edge, also during reset.
`define THM_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);
`else
`define THM_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define THM_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

// ----- hdl/thm_pkg.sv -----
// Shared types and constants of the hysteresis thermostat.
package thm_pkg;

    localparam int unsigned CFG_INDEX_BITS = 3;
    localparam int unsigned FAULT_BITS     = 4;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_NOMINAL_LOW   = 3'd0,
        REG_NOMINAL_HIGH  = 3'd1,
        REG_SETPOINT_BIAS = 3'd2,
        REG_AND_LOGIC     = 3'd3,
        REG_OVERRIDE_LOW  = 3'd4,
        REG_OVERRIDE_HIGH = 3'd5,
        REG_FAULT_FLAGS   = 3'd6
    } cfg_reg_t;

    // Bit positions within fault_flags.
    localparam int unsigned FAULT_OVR_LOW   = 0;
    localparam int unsigned FAULT_OVR_HIGH  = 1;
    localparam int unsigned FAULT_FORCE_ON  = 2;
    localparam int unsigned FAULT_FORCE_OFF = 3;

endpackage

// ----- hdl/thm_if.sv -----
// Channel interfaces of the thermostat: sensor words, result words, config writes.
interface thm_in_if #(parameter int unsigned TEMP_BITS = 16);
    logic                 valid;
    logic                 ready;
    logic [TEMP_BITS-1:0] sensed_temp;
    logic                 last_sensor;

    modport source (output valid, output sensed_temp, output last_sensor, input ready);
    modport sink   (input valid, input sensed_temp, input last_sensor, output ready);
endinterface

interface thm_out_if;
    logic valid;
    logic ready;
    logic heater_actual;
    logic heater_nominal;
    logic heater_setpoint;

    modport source (output valid, output heater_actual, output heater_nominal,
                    output heater_setpoint, input ready);
    modport sink   (input valid, input heater_actual, input heater_nominal,
                    input heater_setpoint, output ready);
endinterface

interface thm_cfg_if #(parameter int unsigned DATA_BITS = 16);
    logic                       valid;
    logic                       ready;
    logic [thm_pkg::CFG_INDEX_BITS-1:0] index;
    logic [DATA_BITS-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/multi_sensor_hysteresis_thermostat_unit.sv -----
// Top level of the multi-sensor hysteresis thermostat.
//
// Usage: sensor readings arrive one word per cycle on the sensor channel
// while it is ready; last_sensor marks the final reading of a tick. Only
// that word yields a result word on the result channel carrying
// heater_actual, heater_nominal and heater_setpoint. Configuration writes
// go over the cfg channel (always ready) by register index; the user must
// make them only while the block is idle, as the block does not enforce it.
// A reading is held in the input register and is judged as it leaves; the
// result word of a last reading is registered in the output register.
// Throughput: one reading per cycle, set by the single pass of two comparator
// pairs between the input and result registers, while no last reading is held back.
// Reset clears the registers to their defaults, both previous commands and
// the primary-seen flags, and empties both stages.
// When the receiver stalls, the held result waits in the output register;
// readings without the last mark keep flowing, and a last reading waits in
// the input register, then the sensor channel stalls behind it.
`include "assert_macros.svh"

module multi_sensor_hysteresis_thermostat_unit #(
    parameter int unsigned TEMP_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    thm_in_if.sink    sensor,
    thm_out_if.source result,
    thm_cfg_if.sink   cfg
);
    import thm_pkg::*;

    localparam int unsigned SP_BITS = TEMP_BITS + 2;

    // Configuration registers.
    logic [TEMP_BITS-1:0]  nominal_low_reg;
    logic [TEMP_BITS-1:0]  nominal_high_reg;
    logic [TEMP_BITS-1:0]  setpoint_bias_reg;
    logic                  and_logic_reg;
    logic [TEMP_BITS-1:0]  override_low_reg;
    logic [TEMP_BITS-1:0]  override_high_reg;
    logic [FAULT_BITS-1:0] fault_flags_reg;

    // Input stage.
    logic                 s1_valid_reg;
    logic [TEMP_BITS-1:0] s1_temp_reg;
    logic                 s1_last_reg;

    // Thermostat state.
    logic prev_nom_reg;
    logic prev_spt_reg;
    logic nom_seen_reg;
    logic spt_seen_reg;
    logic nom_seen_next;
    logic spt_seen_next;

    // Result stage.
    logic out_valid_reg;
    logic out_actual_reg;
    logic out_nominal_reg;
    logic out_setpoint_reg;
    logic out_actual_next;
    logic out_nominal_next;
    logic out_setpoint_next;

    logic in_accept;
    logic out_free;
    logic s1_fire;
    logic s1_emit;

    logic                      primary;
    logic signed [SP_BITS-1:0] bias_ext;
    logic signed [SP_BITS-1:0] nom_lo;
    logic signed [SP_BITS-1:0] nom_hi;
    logic signed [SP_BITS-1:0] spt_lo;
    logic signed [SP_BITS-1:0] spt_hi;
    logic                      ovr_any;
    logic                      spt_dflt;
    logic                      nom_cmd;
    logic                      spt_cmd;
    logic                      nom_hit;
    logic                      spt_hit;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_low_reg   <= '0;
            nominal_high_reg  <= '1;
            setpoint_bias_reg <= '0;
            and_logic_reg     <= 1'b0;
            override_low_reg  <= '0;
            override_high_reg <= '1;
            fault_flags_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_NOMINAL_LOW:   nominal_low_reg   <= cfg.data;
                REG_NOMINAL_HIGH:  nominal_high_reg  <= cfg.data;
                REG_SETPOINT_BIAS: setpoint_bias_reg <= cfg.data;
                REG_AND_LOGIC:     and_logic_reg     <= cfg.data[0];
                REG_OVERRIDE_LOW:  override_low_reg  <= cfg.data;
                REG_OVERRIDE_HIGH: override_high_reg <= cfg.data;
                REG_FAULT_FLAGS:   fault_flags_reg   <= cfg.data[FAULT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: a last word may leave the input stage only when the result slot frees.
    assign out_free     = !out_valid_reg || result.ready;
    assign s1_fire      = s1_valid_reg && (!s1_last_reg || out_free);
    assign s1_emit      = s1_fire && s1_last_reg;
    assign sensor.ready = !s1_valid_reg || s1_fire;
    assign in_accept    = sensor.valid && sensor.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (sensor.ready)
            s1_valid_reg <= sensor.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_temp_reg <= sensor.sensed_temp;
            s1_last_reg <= sensor.last_sensor;
        end
    end

    // Setpoints: nominal plus bias formed exactly two bits wider.
    assign primary  = !and_logic_reg;
    assign bias_ext = signed'({{2{setpoint_bias_reg[TEMP_BITS-1]}}, setpoint_bias_reg});
    assign nom_lo   = signed'({2'b00, nominal_low_reg}) + bias_ext;
    assign nom_hi   = signed'({2'b00, nominal_high_reg}) + bias_ext;
    assign spt_lo   = fault_flags_reg[FAULT_OVR_LOW]
                    ? signed'({2'b00, override_low_reg}) : nom_lo;
    assign spt_hi   = fault_flags_reg[FAULT_OVR_HIGH]
                    ? signed'({2'b00, override_high_reg}) : nom_hi;
    assign ovr_any  = fault_flags_reg[FAULT_OVR_LOW] || fault_flags_reg[FAULT_OVR_HIGH];
    assign spt_dflt = ovr_any ? prev_spt_reg : prev_nom_reg;

    thm_judge #(.TEMP_BITS(TEMP_BITS)) u_judge_nom (
        .temp (s1_temp_reg),
        .lo   (nom_lo),
        .hi   (nom_hi),
        .dflt (prev_nom_reg),
        .cmd  (nom_cmd)
    );

    thm_judge #(.TEMP_BITS(TEMP_BITS)) u_judge_spt (
        .temp (s1_temp_reg),
        .lo   (spt_lo),
        .hi   (spt_hi),
        .dflt (spt_dflt),
        .cmd  (spt_cmd)
    );

    assign nom_hit = nom_seen_reg || (nom_cmd == primary);
    assign spt_hit = spt_seen_reg || (spt_cmd == primary);

    always_comb
    begin
        out_nominal_next  = nom_hit ? primary : !primary;
        out_setpoint_next = spt_hit ? primary : !primary;
        priority if (fault_flags_reg[FAULT_FORCE_ON])
            out_actual_next = 1'b1;
        else if (fault_flags_reg[FAULT_FORCE_OFF])
            out_actual_next = 1'b0;
        else
            out_actual_next = out_setpoint_next;
        // Drop the seen flags at the end of a tick.
        nom_seen_next = s1_last_reg ? 1'b0 : nom_hit;
        spt_seen_next = s1_last_reg ? 1'b0 : spt_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_nom_reg <= 1'b0;
            prev_spt_reg <= 1'b0;
            nom_seen_reg <= 1'b0;
            spt_seen_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            nom_seen_reg <= nom_seen_next;
            spt_seen_reg <= spt_seen_next;
            if (s1_last_reg)
            begin
                prev_nom_reg <= out_nominal_next;
                prev_spt_reg <= out_setpoint_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_emit;
    end

    always_ff @(posedge clk)
    begin
        if (s1_emit)
        begin
            out_actual_reg   <= out_actual_next;
            out_nominal_reg  <= out_nominal_next;
            out_setpoint_reg <= out_setpoint_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.heater_actual   = out_actual_reg;
    assign result.heater_nominal  = out_nominal_reg;
    assign result.heater_setpoint = out_setpoint_reg;

    `THM_ASSERT(a_out_from_last, clk, rst_n, $rose(out_valid_reg) |-> $past(s1_emit), "result word without a last reading")
    `THM_ASSERT(a_seen_cleared, clk, rst_n, $past(s1_emit) |-> (!nom_seen_reg && !spt_seen_reg), "seen flags not cleared after tick")
    `THM_ASSERT(a_force_on, clk, rst_n, (s1_emit && fault_flags_reg[FAULT_FORCE_ON]) |=> out_actual_reg, "force on not applied")
    `THM_ASSERT(a_stall_cause, clk, rst_n, !sensor.ready |-> (s1_valid_reg && s1_last_reg && out_valid_reg), "sensor stalled without a blocked last word")

endmodule

// ----- hdl/thm_judge.sv -----
// Hysteresis decision of one reading against a signed low/high setpoint pair.
module thm_judge #(
    parameter int unsigned TEMP_BITS = 16
) (
    input  logic [TEMP_BITS-1:0]        temp,
    input  logic signed [TEMP_BITS+1:0] lo,
    input  logic signed [TEMP_BITS+1:0] hi,
    input  logic                        dflt,
    output logic                        cmd
);
    logic signed [TEMP_BITS+1:0] temp_s;

    assign temp_s = signed'({2'b00, temp});

    // High trip is tested first, so where both trips hold, as with an inverted pair, it gives off.
    always_comb
    begin
        priority if (temp_s > hi)
            cmd = 1'b0;
        else if (temp_s < lo)
            cmd = 1'b1;
        else
            cmd = dflt;
    end
endmodule
